// ===== sv/mvm_pkg.sv =====
// mvm_pkg: shared types and constants of the 4x4 fixed-point matrix-vector multiplier
// no dependencies
`default_nettype none

package mvm_pkg;

  localparam int unsigned N          = 4;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned ROW_W      = 2;
  localparam int unsigned PROD_W     = 2 * ELEM_W;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_t;

  typedef logic [N-1:0][ELEM_W-1:0] row_t;
  typedef row_t [N-1:0]             mat_t;
  typedef logic [N-1:0][SUM_W-1:0]  sums_t;

  typedef struct packed {
    cmd_t                     command;
    logic [ROW_W-1:0]         row_index;
    logic signed [ELEM_W-1:0] elem_0;
    logic signed [ELEM_W-1:0] elem_1;
    logic signed [ELEM_W-1:0] elem_2;
    logic signed [ELEM_W-1:0] elem_3;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_0;
    logic signed [ELEM_W-1:0] out_1;
    logic signed [ELEM_W-1:0] out_2;
    logic signed [ELEM_W-1:0] out_3;
    logic                     saturated;
  } out_t;

  // per-stage valid bits of the arithmetic pipe
  typedef struct packed {
    logic v1;
    logic v2;
    logic v3;
  } pipe_vld_t;

  // per-stage load enables of the arithmetic pipe
  typedef struct packed {
    logic rdy1;
    logic rdy2;
    logic rdy3;
  } pipe_rdy_t;

endpackage

`default_nettype wire

// ===== sv/mvm_store.sv =====
// mvm_store: 4x4 matrix register file, one row written per load beat
// depends on mvm_pkg
`default_nettype none

module mvm_store (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire  [mvm_pkg::ROW_W-1:0]    wr_row,
  input  wire  mvm_pkg::row_t          wr_data,
  output mvm_pkg::mat_t                mat
);

  mvm_pkg::mat_t mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (wr_en) begin
      mat_r[wr_row] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

`default_nettype wire

// ===== sv/mvm_mac.sv =====
// mvm_mac: products, pair sums and row sums, three register stages
// depends on mvm_pkg
`default_nettype none

module mvm_mac (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire  mvm_pkg::mat_t mat,
  input  wire  mvm_pkg::row_t vec,
  input  wire  mvm_pkg::pipe_rdy_t rdy,
  output mvm_pkg::pipe_vld_t  vld,
  output mvm_pkg::sums_t      sums
);

  logic signed [mvm_pkg::PROD_W-1:0] prod_r   [mvm_pkg::N][mvm_pkg::N];
  logic signed [mvm_pkg::PROD_W-1:0] prod_nxt [mvm_pkg::N][mvm_pkg::N];
  logic signed [mvm_pkg::PAIR_W-1:0] pair_r   [mvm_pkg::N][2];
  logic signed [mvm_pkg::PAIR_W-1:0] pair_nxt [mvm_pkg::N][2];
  logic signed [mvm_pkg::SUM_W-1:0]  sum_r    [mvm_pkg::N];
  logic signed [mvm_pkg::SUM_W-1:0]  sum_nxt  [mvm_pkg::N];
  logic v1_r, v2_r, v3_r;

  // stage 1: sixteen independent products
  always_comb begin
    for (int r = 0; r < mvm_pkg::N; r++) begin
      for (int k = 0; k < mvm_pkg::N; k++) begin
        prod_nxt[r][k] = mvm_pkg::PROD_W'($signed(mat[r][k]))
                       * mvm_pkg::PROD_W'($signed(vec[k]));
      end
    end
  end

  // stage 2: pairs, stage 3: full row sums
  always_comb begin
    for (int r = 0; r < mvm_pkg::N; r++) begin
      pair_nxt[r][0] = mvm_pkg::PAIR_W'(prod_r[r][0]) + mvm_pkg::PAIR_W'(prod_r[r][1]);
      pair_nxt[r][1] = mvm_pkg::PAIR_W'(prod_r[r][2]) + mvm_pkg::PAIR_W'(prod_r[r][3]);
      sum_nxt[r]     = mvm_pkg::SUM_W'(pair_r[r][0]) + mvm_pkg::SUM_W'(pair_r[r][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy.rdy1) prod_r <= prod_nxt;
    if (rdy.rdy2) pair_r <= pair_nxt;
    if (rdy.rdy3) sum_r  <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy.rdy1) v1_r <= start;
      if (rdy.rdy2) v2_r <= v1_r;
      if (rdy.rdy3) v3_r <= v2_r;
    end
  end

  assign vld.v1 = v1_r;
  assign vld.v2 = v2_r;
  assign vld.v3 = v3_r;

  always_comb begin
    for (int r = 0; r < mvm_pkg::N; r++) begin
      sums[r] = sum_r[r];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mvm_sat.sv =====
// mvm_sat: shift, saturate and output register of the four row sums
// depends on mvm_pkg
`default_nettype none

module mvm_sat #(
  parameter int unsigned FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  wire                  in_vld,
  input  wire  mvm_pkg::sums_t sums,
  output logic                 out_vld,
  output mvm_pkg::out_t        out_data
);

  localparam int unsigned HI_W = mvm_pkg::SUM_W - mvm_pkg::ELEM_W + 1;

  logic signed [mvm_pkg::SUM_W-1:0] sh;
  logic [HI_W-1:0]                  hi;
  logic [mvm_pkg::N-1:0]            clip;
  logic [mvm_pkg::N-1:0][mvm_pkg::ELEM_W-1:0] res;
  mvm_pkg::out_t out_data_r, out_data_nxt;
  logic          out_vld_r;

  always_comb begin
    clip = '0;
    res  = '0;
    sh   = '0;
    hi   = '0;
    for (int r = 0; r < mvm_pkg::N; r++) begin
      sh = $signed(sums[r]) >>> FRAC_BITS;
      hi = sh[mvm_pkg::SUM_W-1:mvm_pkg::ELEM_W-1];
      // bits above the 32-bit sign must all match it
      if (!sh[mvm_pkg::SUM_W-1] && (|hi)) begin
        res[r]  = mvm_pkg::SAT_MAX;
        clip[r] = 1'b1;
      end else if (sh[mvm_pkg::SUM_W-1] && !(&hi)) begin
        res[r]  = mvm_pkg::SAT_MIN;
        clip[r] = 1'b1;
      end else begin
        res[r]  = sh[mvm_pkg::ELEM_W-1:0];
      end
    end
    out_data_nxt.out_0     = res[0];
    out_data_nxt.out_1     = res[1];
    out_data_nxt.out_2     = res[2];
    out_data_nxt.out_3     = res[3];
    out_data_nxt.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= in_vld;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ===== sv/matrix_vector_multiply.sv =====
// matrix_vector_multiply: 4x4 signed Q16.16 matrix times vector, saturated
// a multiply beat passes the product, pair-sum, row-sum and output registers in that order before it shows on out_
// throughput: one beat per cycle, loads and multiplies alike, unless out_stall backs up the pipe; every stage of
// product, pair-sum, row-sum and saturate registers stalls on its own, squeezing out bubbles
// reset: synchronous active-low rst_n clears all valid bits and the matrix to zero
// depends on mvm_pkg, mvm_store, mvm_mac, mvm_sat
`default_nettype none

module matrix_vector_multiply #(
  parameter int unsigned FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  mvm_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output mvm_pkg::out_t        out_data
);

  mvm_pkg::mat_t      mat;
  mvm_pkg::row_t      in_row;
  mvm_pkg::pipe_vld_t vld;
  mvm_pkg::pipe_rdy_t rdy;
  mvm_pkg::sums_t     sums;
  logic               rdy4;
  logic               in_fire;

  assign in_row = {in_data.elem_3, in_data.elem_2, in_data.elem_1, in_data.elem_0};

  // each stage takes new data when empty or when the next one moves
  assign rdy4     = !out_valid || !out_stall;
  assign rdy.rdy3 = !vld.v3 || rdy4;
  assign rdy.rdy2 = !vld.v2 || rdy.rdy3;
  assign rdy.rdy1 = !vld.v1 || rdy.rdy2;
  assign in_stall = !rdy.rdy1;
  assign in_fire  = in_valid && !in_stall;

  mvm_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && (in_data.command == mvm_pkg::CMD_LOAD)),
    .wr_row  (in_data.row_index),
    .wr_data (in_row),
    .mat     (mat)
  );

  mvm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && (in_data.command == mvm_pkg::CMD_MUL)),
    .mat   (mat),
    .vec   (in_row),
    .rdy   (rdy),
    .vld   (vld),
    .sums  (sums)
  );

  mvm_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (rdy4),
    .in_vld   (vld.v3),
    .sums     (sums),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  // a multiply beat always lands in the product stage
  a_mul_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.command == mvm_pkg::CMD_MUL) |=> vld.v1)
    else $error("accepted multiply did not reach product stage");

  // input stalls only when every stage holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld.v1 && vld.v2 && vld.v3 && out_valid && out_stall))
    else $error("input stalled with a free stage");

  // clip flag implies at least one result sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_0 == mvm_pkg::SAT_MAX || out_data.out_0 == mvm_pkg::SAT_MIN ||
       out_data.out_1 == mvm_pkg::SAT_MAX || out_data.out_1 == mvm_pkg::SAT_MIN ||
       out_data.out_2 == mvm_pkg::SAT_MAX || out_data.out_2 == mvm_pkg::SAT_MIN ||
       out_data.out_3 == mvm_pkg::SAT_MAX || out_data.out_3 == mvm_pkg::SAT_MIN))
    else $error("saturated flag without a clipped value");

endmodule

`default_nettype wire

// ===== sim/tb_matrix_vector_multiply.sv =====
// tb_matrix_vector_multiply: self-checking testbench of the 4x4 fixed-point matrix-vector block
// predicts each multiply beat from its own copy of the matrix and checks out_ beats in order
// depends on mvm_pkg and matrix_vector_multiply

module tb_matrix_vector_multiply;

  localparam int FRAC = mvm_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TOTAL_BEATS = 1750;
  localparam logic signed [65:0] SUM_TOP = 66'sd2147483647;
  localparam logic signed [65:0] SUM_BOTTOM = -66'sd2147483648;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    mvm_pkg::in_t beat;
    bit           drain;
  } queued_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  mvm_pkg::in_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  mvm_pkg::out_t out_data;

  queued_beat_t beat_queue[$];
  mvm_pkg::out_t pending_sums[$];
  logic signed [31:0] coef [16];
  int beats_queued = 0;
  int beats_sent = 0;
  int sums_checked = 0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  logic fire;
  mvm_pkg::out_t want;

  matrix_vector_multiply #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // exact 66-bit sums, floor shift, clip to 32 bits
  function automatic mvm_pkg::out_t dot_products(input mvm_pkg::in_t b);
    logic signed [31:0] vec [4];
    logic signed [31:0] res [4];
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    logic clipped;
    int i;
    int k;
    mvm_pkg::out_t r;
    vec[0] = b.elem_0;
    vec[1] = b.elem_1;
    vec[2] = b.elem_2;
    vec[3] = b.elem_3;
    clipped = 1'b0;
    for (i = 0; i < 4; i++) begin
      acc = '0;
      for (k = 0; k < 4; k++) acc = acc + coef[i*4+k] * vec[k];
      scaled = acc >>> FRAC;
      if (scaled > SUM_TOP) begin
        res[i] = mvm_pkg::SAT_MAX;
        clipped = 1'b1;
      end else if (scaled < SUM_BOTTOM) begin
        res[i] = mvm_pkg::SAT_MIN;
        clipped = 1'b1;
      end else begin
        res[i] = scaled[31:0];
      end
    end
    r.out_0 = res[0];
    r.out_1 = res[1];
    r.out_2 = res[2];
    r.out_3 = res[3];
    r.saturated = clipped;
    return r;
  endfunction

  task automatic take_beat(input mvm_pkg::in_t b);
    if (b.command == mvm_pkg::CMD_LOAD) begin
      coef[b.row_index*4+0] = b.elem_0;
      coef[b.row_index*4+1] = b.elem_1;
      coef[b.row_index*4+2] = b.elem_2;
      coef[b.row_index*4+3] = b.elem_3;
    end else begin
      pending_sums.push_back(dot_products(b));
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("mismatch on %s: got %h, expected %h", what, got, exp_val);
    errors++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 94) return $urandom_range(1, 3);
    else return $urandom_range(6, 30);
  endfunction

  function automatic logic [31:0] pick_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    else if (r < 60) return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    else if (r < 85) return $urandom;
    case ($urandom_range(0, 5))
      0: return mvm_pkg::SAT_MAX;
      1: return mvm_pkg::SAT_MIN;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      default: return ONE;
    endcase
  endfunction

  task automatic queue_beat(input mvm_pkg::cmd_t c, input logic [1:0] row,
                            input logic [31:0] e0,
                            input logic [31:0] e1, input logic [31:0] e2,
                            input logic [31:0] e3);
    mvm_pkg::in_t b;
    bit d;
    b.command = c;
    b.row_index = row;
    b.elem_0 = e0;
    b.elem_1 = e1;
    b.elem_2 = e2;
    b.elem_3 = e3;
    // every 600 beats the sender waits for the pipe to empty
    d = (beats_queued > 0 && beats_queued % 600 == 0);
    beat_queue.push_back('{beat: b, drain: d});
    beats_queued++;
  endtask

  // driver
  always @(posedge clk) begin
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        take_beat(in_data);
        beats_sent++;
        if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : pick_gap();
      end
      if (in_valid && !fire) begin
        // stalled beat stays on the bus
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (beat_queue.size() > 0 &&
                   !(beat_queue[0].drain && pending_sums.size() > 0)) begin
        in_data <= beat_queue[0].beat;
        in_valid <= 1'b1;
        void'(beat_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_sums.size() == 0) begin
          flag_mismatch("unexpected beat out_0", out_data.out_0, 32'h0);
        end else begin
          want = pending_sums.pop_front();
          if (out_data.out_0 !== want.out_0) flag_mismatch("out_0", out_data.out_0, want.out_0);
          if (out_data.out_1 !== want.out_1) flag_mismatch("out_1", out_data.out_1, want.out_1);
          if (out_data.out_2 !== want.out_2) flag_mismatch("out_2", out_data.out_2, want.out_2);
          if (out_data.out_3 !== want.out_3) flag_mismatch("out_3", out_data.out_3, want.out_3);
          if (out_data.saturated !== want.saturated)
            flag_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
          sums_checked++;
          // long hold-off so the pipe fills and backs up the input
          if (sums_checked % 500 == 150) hold_left = 90;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 119) == 0) recv_calm = !recv_calm;
        if (!recv_calm) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int j;
    int tmp;
    int n_mul;
    int order [4];
    for (r = 0; r < 16; r++) coef[r] = '0;

    // multiply against the all-zero matrix left by reset
    queue_beat(mvm_pkg::CMD_MUL, 2'd3, mvm_pkg::SAT_MAX, mvm_pkg::SAT_MIN, 32'h1,
               32'hFFFF_FFFF);
    // identity, then extremes pass straight through
    for (r = 0; r < 4; r++)
      queue_beat(mvm_pkg::CMD_LOAD, r[1:0], (r == 0) ? ONE : 0, (r == 1) ? ONE : 0,
                 (r == 2) ? ONE : 0, (r == 3) ? ONE : 0);
    queue_beat(mvm_pkg::CMD_MUL, 2'd1, mvm_pkg::SAT_MAX, mvm_pkg::SAT_MIN, 32'h0,
               32'hFFFF_FFFF);
    queue_beat(mvm_pkg::CMD_MUL, 2'd0, 32'h1, 32'h2, 32'h3, 32'h4);
    // all-max matrix: positive and negative overflow
    for (r = 0; r < 4; r++)
      queue_beat(mvm_pkg::CMD_LOAD, r[1:0], mvm_pkg::SAT_MAX, mvm_pkg::SAT_MAX,
                 mvm_pkg::SAT_MAX, mvm_pkg::SAT_MAX);
    queue_beat(mvm_pkg::CMD_MUL, 2'd2, mvm_pkg::SAT_MAX, mvm_pkg::SAT_MAX,
               mvm_pkg::SAT_MAX, mvm_pkg::SAT_MAX);
    queue_beat(mvm_pkg::CMD_MUL, 2'd0, mvm_pkg::SAT_MIN, mvm_pkg::SAT_MIN,
               mvm_pkg::SAT_MIN, mvm_pkg::SAT_MIN);
    // rows around the clip limits and the floor rounding
    queue_beat(mvm_pkg::CMD_LOAD, 2'd0, mvm_pkg::SAT_MIN, mvm_pkg::SAT_MIN,
               mvm_pkg::SAT_MIN, mvm_pkg::SAT_MIN);
    queue_beat(mvm_pkg::CMD_LOAD, 2'd1, mvm_pkg::SAT_MIN, 32'h0, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_LOAD, 2'd2, 32'h1, 32'h0, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_LOAD, 2'd3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_MUL, 2'd0, mvm_pkg::SAT_MIN, mvm_pkg::SAT_MIN,
               mvm_pkg::SAT_MIN, mvm_pkg::SAT_MIN);
    queue_beat(mvm_pkg::CMD_MUL, 2'd3, ONE, 32'h0, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_MUL, 2'd1, 32'h1, 32'h0, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_MUL, 2'd2, ONE + 32'h1, 32'h0, 32'h0, 32'h0);
    // overwrite a row, then land one step past the positive limit
    queue_beat(mvm_pkg::CMD_LOAD, 2'd2, mvm_pkg::SAT_MAX, mvm_pkg::SAT_MAX, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_LOAD, 2'd2, ONE, ONE, 32'h0, 32'h0);
    queue_beat(mvm_pkg::CMD_MUL, 2'd0, mvm_pkg::SAT_MAX, 32'h1, 32'h0, 32'h0);

    while (beats_queued < TOTAL_BEATS) begin
      if ($urandom_range(0, 99) < 80) begin
        // full matrix in shuffled row order, then a run of vectors
        for (j = 0; j < 4; j++) order[j] = j;
        for (j = 3; j > 0; j--) begin
          r = $urandom_range(0, j);
          tmp = order[j];
          order[j] = order[r];
          order[r] = tmp;
        end
        for (j = 0; j < 4; j++)
          queue_beat(mvm_pkg::CMD_LOAD, order[j][1:0], pick_elem(), pick_elem(),
                     pick_elem(), pick_elem());
        n_mul = $urandom_range(1, 8);
        for (j = 0; j < n_mul; j++)
          queue_beat(mvm_pkg::CMD_MUL, 2'($urandom_range(0, 3)), pick_elem(), pick_elem(),
                     pick_elem(), pick_elem());
      end else begin
        queue_beat(mvm_pkg::cmd_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   pick_elem(), pick_elem(), pick_elem(), pick_elem());
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_sent < beats_queued) @(posedge clk);
    while (pending_sums.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
